@@ rtl/core/lzwd_pkg.sv @@
`default_nettype none

package lzwd_pkg;

  // Token and result field widths.
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_W    = 13;

  // Input item layout in the slave tdata word, lowest field first.
  localparam int unsigned OFFSET_LSB = 0;
  localparam int unsigned LEN_LSB    = OFFSET_LSB + OFFSET_W;
  localparam int unsigned BYTE_LSB   = LEN_LSB + LEN_W;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 8;

  // Window size after reset.
  localparam int unsigned RESET_WINDOW = 4096;

endpackage : lzwd_pkg

`default_nettype wire

@@ rtl/core/lzwd_hist_ram.sv @@
`default_nettype none

module lzwd_hist_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule : lzwd_hist_ram

`default_nettype wire

@@ rtl/core/lzwd_mod_add.sv @@
`default_nettype none

module lzwd_mod_add #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic [AW-1:0] a_i,
  input  wire logic [AW:0]   b_i,
  output      logic [AW-1:0] sum_o
);

  localparam int unsigned SW = AW + 2;

  logic [SW-1:0] sum_raw;

  // The sum stays below twice the depth, so one conditional subtract wraps it.
  always_comb begin
    sum_raw = SW'(a_i) + SW'(b_i);
    if (sum_raw >= SW'(DEPTH)) begin
      sum_raw = sum_raw - SW'(DEPTH);
    end
    sum_o = sum_raw[AW-1:0];
  end

endmodule : lzwd_mod_add

`default_nettype wire

@@ rtl/core/lz77_window_decoder.sv @@
// A literal or bad-offset token shows its result in the cycle after it is accepted.
// A match first forms the start address (ST_ADD), then for each byte does a history
// read (ST_RD) and a load into the output register (ST_DATA), which waits on an output stall.
// The input is held off from a match's acceptance until its last byte is loaded.
// Reset (rst_ni low, asynchronous) empties the window, rewinds the write position and
// sets the window size to 4096; the history memory itself is not cleared.
`default_nettype none

module lz77_window_decoder
  import lzwd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 4096,
  parameter int unsigned MAX_MATCH     = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // tdata: offset[11:0], match_length[18:12], next_byte[26:19], zero fill.
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // tdata: out_byte[7:0].
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [M_TDATA_W-1:0] m_axis_tdata,
  output      logic                 m_axis_tlast,
  // tuser: bad_offset[0].
  output      logic                 m_axis_tuser,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW  = AW + 1;
  localparam int unsigned CW  = (OFFSET_W > FW) ? OFFSET_W : FW;
  localparam int unsigned WW  = (CFG_W > FW) ? CFG_W : FW;
  localparam int unsigned LW  = $clog2(MAX_MATCH + 1);
  localparam int unsigned RESET_LIMIT =
      (RESET_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : RESET_WINDOW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_RD,
    ST_DATA
  } state_e;

  state_e state_q;

  logic [AW-1:0]     wp_q;
  logic [FW-1:0]     fill_q;
  logic [FW-1:0]     limit_q;
  logic [AW-1:0]     src_q;
  logic [AW-1:0]     off_q;
  logic [LW-1:0]     cnt_q;
  logic              out_vld_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_bad_q;

  logic [OFFSET_W-1:0] in_off;
  logic [LEN_W-1:0]    in_len;
  logic [BYTE_W-1:0]   in_byte;
  logic                in_acc;
  logic                in_bad;
  logic [LW-1:0]       in_cnt;
  logic                out_free;
  logic                cfg_acc;
  logic [FW-1:0]       cfg_limit;
  logic [FW-1:0]       fill_inc;

  logic [AW-1:0] add_a;
  logic [FW-1:0] add_b;
  logic [AW-1:0] add_sum;

  logic              ram_we;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  function automatic logic [FW-1:0] clamp_window(input logic [CFG_W-1:0] ws);
    logic [WW-1:0] w;
    w = WW'(ws);
    if (w < WW'(2)) begin
      w = WW'(2);
    end else if (w > WW'(HISTORY_DEPTH)) begin
      w = WW'(HISTORY_DEPTH);
    end
    return w[FW-1:0];
  endfunction

  assign in_off  = s_axis_tdata[OFFSET_LSB +: OFFSET_W];
  assign in_len  = s_axis_tdata[LEN_LSB +: LEN_W];
  assign in_byte = s_axis_tdata[BYTE_LSB +: BYTE_W];

  // A pending configuration write goes first, so an item always sees the new window.
  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free && !cfg_valid_i;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_bad        = CW'(in_off) >= CW'(fill_q);
  assign in_cnt        = (in_len > LEN_W'(MAX_MATCH)) ? LW'(MAX_MATCH) : LW'(in_len);

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_limit   = clamp_window(cfg_data_i);
  assign fill_inc    = (fill_q < limit_q) ? fill_q + FW'(1) : fill_q;

  // Operand selection for the shared modular adder.
  always_comb begin
    add_a = wp_q;
    add_b = FW'(1);
    case (state_q)
      ST_IDLE: begin
        if (in_len != '0) begin
          // Oldest byte of the window: write position minus fill, modulo depth.
          add_b = FW'(HISTORY_DEPTH) - fill_q;
        end
      end
      ST_ADD: begin
        add_a = src_q;
        add_b = FW'(off_q);
      end
      ST_RD: begin
        add_a = src_q;
      end
      ST_DATA: begin
        add_a = wp_q;
      end
      default: begin
        add_a = wp_q;
      end
    endcase
  end

  lzwd_mod_add #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .sum_o (add_sum)
  );

  assign ram_we    = (in_acc && (in_len == '0)) || ((state_q == ST_DATA) && out_free);
  assign ram_wdata = (state_q == ST_IDLE) ? in_byte : ram_rdata;
  assign ram_re    = (state_q == ST_RD);

  lzwd_hist_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (src_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wp_q       <= '0;
      fill_q     <= '0;
      limit_q    <= FW'(RESET_LIMIT);
      out_vld_q  <= 1'b0;
      src_q      <= '0;
      off_q      <= '0;
      cnt_q      <= '0;
      out_byte_q <= '0;
      out_last_q <= 1'b0;
      out_bad_q  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_len == '0) begin
              wp_q       <= add_sum;
              fill_q     <= fill_inc;
              out_vld_q  <= 1'b1;
              out_byte_q <= in_byte;
              out_last_q <= 1'b1;
              out_bad_q  <= 1'b0;
            end else if (in_bad) begin
              out_vld_q  <= 1'b1;
              out_byte_q <= '0;
              out_last_q <= 1'b1;
              out_bad_q  <= 1'b1;
            end else begin
              // The offset is below the fill here, so it fits the address width.
              src_q   <= add_sum;
              off_q   <= AW'(in_off);
              cnt_q   <= in_cnt;
              state_q <= ST_ADD;
            end
          end
        end
        ST_ADD: begin
          src_q   <= add_sum;
          state_q <= ST_RD;
        end
        ST_RD: begin
          src_q   <= add_sum;
          state_q <= ST_DATA;
        end
        ST_DATA: begin
          if (out_free) begin
            wp_q       <= add_sum;
            fill_q     <= fill_inc;
            cnt_q      <= cnt_q - LW'(1);
            out_vld_q  <= 1'b1;
            out_byte_q <= ram_rdata;
            out_last_q <= (cnt_q == LW'(1));
            out_bad_q  <= 1'b0;
            state_q    <= (cnt_q == LW'(1)) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_acc) begin
        limit_q <= cfg_limit;
        if (fill_q > cfg_limit) begin
          fill_q <= cfg_limit;
        end
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

endmodule : lz77_window_decoder

`default_nettype wire

@@ rtl/core/lzwd_checker.sv @@
`default_nettype none

module lzwd_checker
  import lzwd_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                 m_axis_tlast,
  input wire logic                 m_axis_tuser,
  input wire logic                 cfg_ready_o
);

  // An error result carries no byte and closes its token.
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("bad offset result without last or with nonzero byte");

  // A literal item shows up as a single result in the next cycle.
  a_literal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[LEN_LSB +: LEN_W] == '0)
    |=> m_axis_tvalid && m_axis_tlast && !m_axis_tuser
        && (m_axis_tdata == $past(s_axis_tdata[BYTE_LSB +: BYTE_W])))
    else $error("literal item not echoed on the next cycle");

  // The input is only taken while configuration writes are allowed too, i.e. when idle.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> cfg_ready_o)
    else $error("input ready outside idle");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
        && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule : lzwd_checker

bind lz77_window_decoder lzwd_checker u_lzwd_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lzwd_pkg::*;

  localparam int unsigned HIST_DEPTH    = 4096;
  localparam int unsigned MAX_LEN       = 64;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              bad;
  } out_byte_t;

  class decode_scoreboard;
    logic [BYTE_W-1:0] hist [HIST_DEPTH];
    int unsigned       wr_slot;
    int unsigned       valid_count;
    logic [CFG_W-1:0]  size_reg;
    out_byte_t         expected_bytes [$];
    int unsigned       errors;

    function new();
      wr_slot     = 0;
      valid_count = 0;
      size_reg    = CFG_W'(RESET_WINDOW);
      errors      = 0;
    endfunction

    function int unsigned window_limit();
      if (size_reg < 2) return 2;
      if (size_reg > HIST_DEPTH) return HIST_DEPTH;
      return size_reg;
    endfunction

    // A smaller window drops the oldest bytes right away.
    function void set_window(logic [CFG_W-1:0] value);
      size_reg = value;
      if (valid_count > window_limit()) valid_count = window_limit();
    endfunction

    function void append(logic [BYTE_W-1:0] b, int unsigned lim);
      hist[wr_slot] = b;
      wr_slot = (wr_slot + 1) % HIST_DEPTH;
      if (valid_count < lim) valid_count++;
    endfunction

    function void decode_token(logic [OFFSET_W-1:0] off, logic [LEN_W-1:0] len,
                               logic [BYTE_W-1:0] lit);
      int unsigned lim;
      int unsigned count;
      int unsigned base;
      int unsigned i;
      logic [BYTE_W-1:0] b;
      lim = window_limit();
      if (valid_count > lim) valid_count = lim;
      if (len == 0) begin
        append(lit, lim);
        expected_bytes.push_back('{value: lit, last: 1'b1, bad: 1'b0});
        return;
      end
      count = (len > MAX_LEN) ? MAX_LEN : len;
      if (off >= valid_count) begin
        expected_bytes.push_back('{value: '0, last: 1'b1, bad: 1'b1});
        return;
      end
      // The source is fixed by the window as it stood on arrival, so a copy
      // may read bytes that this same token has just produced.
      base = (wr_slot + HIST_DEPTH - valid_count) % HIST_DEPTH;
      for (i = 0; i < count; i++) begin
        b = hist[(base + off + i) % HIST_DEPTH];
        append(b, lim);
        expected_bytes.push_back('{value: b, last: (i + 1 == count), bad: 1'b0});
      end
    endfunction

    function void check_output_byte(logic [BYTE_W-1:0] b, logic last, logic bad);
      out_byte_t exp;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, got byte %02h last %b bad %b",
                 $time, b, last, bad);
        return;
      end
      exp = expected_bytes.pop_front();
      if (b !== exp.value) begin
        errors++;
        $display("%0t: out_byte expected %02h, got %02h", $time, exp.value, b);
      end
      if (last !== exp.last) begin
        errors++;
        $display("%0t: last expected %b, got %b", $time, exp.last, last);
      end
      if (bad !== exp.bad) begin
        errors++;
        $display("%0t: bad_offset expected %b, got %b", $time, exp.bad, bad);
      end
    endfunction

    function void flag_leftover();
      if (expected_bytes.size() != 0) begin
        errors++;
        $display("%0t: expected %0d more items, got none", $time, expected_bytes.size());
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  decode_scoreboard sb;
  int unsigned      send_calm = 0;
  int unsigned      recv_calm = 0;

  lz77_window_decoder #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .MAX_MATCH    (MAX_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Mostly random waits, with an occasional run of back-to-back items.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, 9);
  endfunction

  task automatic send_token(input logic [OFFSET_W-1:0] off, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] lit);
    int unsigned gap;
    gap = draw_gap(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - BYTE_LSB - BYTE_W){1'b0}}, lit, len, off};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.decode_token(off, len, lit);
  endtask

  task automatic stop_tokens();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_random_token();
    int unsigned roll;
    int unsigned span;
    int unsigned r;
    logic [OFFSET_W-1:0] off;
    logic [LEN_W-1:0]    len;
    logic [BYTE_W-1:0]   lit;
    roll = $urandom_range(0, 99);
    span = sb.valid_count;
    lit  = BYTE_W'($urandom);
    off  = OFFSET_W'($urandom);
    r    = $urandom_range(0, 19);
    len  = (r == 0) ? LEN_W'($urandom_range(65, 127)) :
           (r < 10) ? LEN_W'($urandom_range(40, 64)) : LEN_W'($urandom_range(1, 39));
    if (roll < 12 || (span == 0 && roll < 90)) begin
      len = 0;
    end else if ((roll < 22 || span == 0) && span < HIST_DEPTH) begin
      off = OFFSET_W'($urandom_range(HIST_DEPTH - 1, span));
    end else begin
      // Newest byte gives overlapping copies, oldest byte the window edge.
      case ($urandom_range(0, 2))
        0:       off = OFFSET_W'(span - 1);
        1:       off = 0;
        default: off = OFFSET_W'($urandom_range(span - 1, 0));
      endcase
    end
    send_token(off, len, lit);
  endtask

  task automatic wait_for_drain();
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_window(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(recv_calm);
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_output_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_window [6];
    int unsigned      phase_items [6];
    phase_window = '{13'd8191, 13'd2, 13'd0, 13'd1, 13'd300, 13'd4096};
    phase_items  = '{20, 12, 8, 6, 12, 12};
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // A match into the empty window, literals at the byte extremes with the
    // offset ignored, copies at both window ends, and lengths past the cap.
    send_token(0, 1, 8'h00);
    send_token(12'hFFF, 0, 8'h00);
    send_token(0, 0, 8'hFF);
    send_token(12'hAAA, 0, 8'hA5);
    send_token(12'h555, 0, 8'h5A);
    send_token(0, 1, 8'hFF);
    send_token(OFFSET_W'(sb.valid_count - 1), 64, 8'h00);
    send_token(1, 127, 8'hFF);
    send_token(2, 65, 8'h00);
    send_token(OFFSET_W'(sb.valid_count), 3, 8'h00);
    send_token(12'hFFF, 64, 8'h00);
    send_token(OFFSET_W'(sb.valid_count - 1), 2, 8'h00);
    send_token(0, 0, 8'h80);
    stop_tokens();
    wait_for_drain();

    repeat (30) send_random_token();
    stop_tokens();

    for (int p = 0; p < 6; p++) begin
      wait_for_drain();
      write_window(phase_window[p]);
      repeat (phase_items[p]) send_random_token();
      stop_tokens();
    end

    wait_for_drain();
    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
